[rtl/escape_sequence_key_decoder_top_macros.svh]
// ============================================================================
// Escape sequence key decoder assertion macros
// Clocked assertion wrappers used by the decoder top module.
// ============================================================================
`ifndef ESCAPE_SEQUENCE_KEY_DECODER_TOP_MACROS_SVH
`define ESCAPE_SEQUENCE_KEY_DECODER_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ESCKD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ESCKD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/esckd_pkg.sv]
// ============================================================================
// Escape sequence key decoder package
// Parser states, byte and key constants, key maps and the shared beat type.
// ============================================================================
`timescale 1ns / 1ps

package esckd_pkg;

   // Parser states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_ESC  = 2'd1,
      ST_WAIT = 2'd2
   } parse_state_type;

   // Input operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Terminal bytes
   localparam logic [7:0] BYTE_ESC = 8'h1B;
   localparam logic [7:0] BYTE_LB  = 8'h5B;
   localparam logic [7:0] FINAL_LO = 8'h40;
   localparam logic [7:0] FINAL_HI = 8'h7E;

   // Key codes
   localparam logic [7:0] KC_NONE = 8'd0;
   localparam logic [7:0] KC_ESC  = 8'd1;

   // Timeout register reset value
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // Default depth of the result queue
   localparam int RSP_DEPTH = 4;

   // Keys produced by one accepted input beat
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] key0;
      logic [7:0] key1;
   } key_beat_type;

   // Map a plain byte to its key, none when unmapped
   function automatic logic [7:0] plain_key(input logic [7:0] b);
      logic [7:0] k;
      unique case (b)
         8'h1B:   k = 8'd1;
         8'h30:   k = 8'd11;
         8'h31:   k = 8'd2;
         8'h32:   k = 8'd3;
         8'h33:   k = 8'd4;
         8'h34:   k = 8'd5;
         8'h35:   k = 8'd6;
         8'h36:   k = 8'd7;
         8'h37:   k = 8'd8;
         8'h38:   k = 8'd9;
         8'h39:   k = 8'd10;
         8'h20:   k = 8'd57;
         8'h71:   k = 8'd16;
         8'h51:   k = 8'd16;
         8'h0A:   k = 8'd28;
         default: k = KC_NONE;
      endcase
      return k;
   endfunction

   // Map a final byte to its arrow key, none when unmapped
   function automatic logic [7:0] final_key(input logic [7:0] b);
      logic [7:0] k;
      unique case (b)
         8'h41:   k = 8'd103;
         8'h42:   k = 8'd108;
         8'h43:   k = 8'd106;
         8'h44:   k = 8'd105;
         default: k = KC_NONE;
      endcase
      return k;
   endfunction

endpackage

[rtl/escape_sequence_key_decoder_top.sv]
// ============================================================================
// Escape sequence key decoder
// Terminal bytes and ticks in, Linux key codes out.
// ============================================================================
// Each accepted req beat is parsed in the cycle it arrives and its keys
// (zero, one or two) land in a small result queue of RSP_DEPTH entries; a
// new req beat is taken every cycle while the queue has room for two keys.
// The rsp side drains one key per cycle while rsp_ready is high; a beat
// that yields two keys (ESC then a mapped byte other than ESC) takes two
// rsp handshakes. rsp_last marks the final key produced by one req beat.
// The escape timeout is set by the csr write port, which is always ready
// and takes effect on the next beat.
`timescale 1ns / 1ps
`include "escape_sequence_key_decoder_top_macros.svh"

module escape_sequence_key_decoder_top #(
   parameter int RSP_DEPTH = esckd_pkg::RSP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_key_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_escape_timeout_ticks
);

   localparam int OCC_W = $clog2(RSP_DEPTH + 1);

   logic                    req_accept;
   logic                    rsp_pop;
   logic [1:0]              push;
   logic [OCC_W-1:0]        occupancy;
   logic [15:0]             timeout_ff;
   esckd_pkg::key_beat_type beat;

   // Take a req beat only when the queue can absorb two keys
   assign req_ready  = (occupancy <= OCC_W'(RSP_DEPTH - 2));
   assign req_accept = req_valid && req_ready;
   assign rsp_pop    = rsp_valid && rsp_ready;
   assign push       = req_accept ? beat.count : 2'd0;
   assign csr_ready  = 1'b1;

   // Hold the timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= esckd_pkg::TIMEOUT_RESET;
      end else if (csr_valid) begin
         timeout_ff <= csr_escape_timeout_ticks;
      end
   end

   esckd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .operation     (req_operation),
      .byte_value    (req_byte_value),
      .timeout_ticks (timeout_ff),
      .beat          (beat)
   );

   esckd_key_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_key_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .beat      (beat),
      .pop       (rsp_pop),
      .valid     (rsp_valid),
      .key_code  (rsp_key_code),
      .last      (rsp_last),
      .occupancy (occupancy)
   );

   // Queue never overfills
   `ESCKD_ASSERT(a_no_overflow, occupancy <= OCC_W'(RSP_DEPTH), "result queue overflow")

   // Occupancy tracks pushed and popped keys
   `ESCKD_ASSERT(a_occ_track, !$past(reset) |-> (occupancy == $past(occupancy) + OCC_W'($past(push)) - OCC_W'($past(rsp_pop))), "result queue count mismatch")

   // Reset empties the queue
   `ESCKD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result queue not empty after reset")

endmodule

[rtl/esckd_parser.sv]
// ============================================================================
// Escape sequence parser
// Three-state parser with elapsed tick counter; yields up to two keys a beat.
// ============================================================================
`timescale 1ns / 1ps

module esckd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   operation,
   input  logic [7:0]             byte_value,
   input  logic [15:0]            timeout_ticks,
   output esckd_pkg::key_beat_type beat
);

   esckd_pkg::parse_state_type state_ff, state_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [16:0] tick_sum;
   logic        tick_fire;
   logic        in_final;
   logic [7:0]  plain_k;
   logic [7:0]  final_k;

   // Shared lookups and compares
   assign tick_sum  = {1'b0, elapsed_ff} + 17'd1;
   assign tick_fire = tick_sum > {1'b0, timeout_ticks};
   assign in_final  = (byte_value >= esckd_pkg::FINAL_LO) &&
                      (byte_value <= esckd_pkg::FINAL_HI);
   assign plain_k   = esckd_pkg::plain_key(byte_value);
   assign final_k   = esckd_pkg::final_key(byte_value);

   // Next state and elapsed count
   always_comb begin
      state_in   = state_ff;
      elapsed_in = elapsed_ff;
      if (operation == esckd_pkg::OP_TICK) begin
         if (state_ff != esckd_pkg::ST_IDLE) begin
            if (tick_fire) begin
               state_in = esckd_pkg::ST_IDLE;
            end else begin
               elapsed_in = tick_sum[15:0];
            end
         end
      end else begin
         unique case (state_ff)
            esckd_pkg::ST_IDLE: begin
               if (byte_value == esckd_pkg::BYTE_ESC) begin
                  state_in   = esckd_pkg::ST_ESC;
                  elapsed_in = '0;
               end
            end
            esckd_pkg::ST_ESC: begin
               if (byte_value == esckd_pkg::BYTE_LB) begin
                  state_in = esckd_pkg::ST_WAIT;
               end else if (byte_value != esckd_pkg::BYTE_ESC) begin
                  state_in = esckd_pkg::ST_IDLE;
               end
            end
            esckd_pkg::ST_WAIT: begin
               if (in_final) begin
                  state_in = esckd_pkg::ST_IDLE;
               end
            end
            default: begin
               state_in = esckd_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // Keys emitted by this beat
   always_comb begin
      beat.count = 2'd0;
      beat.key0  = esckd_pkg::KC_ESC;
      beat.key1  = plain_k;
      if (operation == esckd_pkg::OP_TICK) begin
         if ((state_ff != esckd_pkg::ST_IDLE) && tick_fire) begin
            beat.count = 2'd1;
         end
      end else begin
         unique case (state_ff)
            esckd_pkg::ST_IDLE: begin
               beat.key0 = plain_k;
               if ((byte_value != esckd_pkg::BYTE_ESC) && (plain_k != esckd_pkg::KC_NONE)) begin
                  beat.count = 2'd1;
               end
            end
            esckd_pkg::ST_ESC: begin
               if (byte_value == esckd_pkg::BYTE_ESC) begin
                  beat.count = 2'd1;
               end else if (byte_value != esckd_pkg::BYTE_LB) begin
                  beat.count = (plain_k != esckd_pkg::KC_NONE) ? 2'd2 : 2'd1;
               end
            end
            esckd_pkg::ST_WAIT: begin
               beat.key0 = final_k;
               if (in_final && (final_k != esckd_pkg::KC_NONE)) begin
                  beat.count = 2'd1;
               end
            end
            default: begin
               beat.count = 2'd0;
            end
         endcase
      end
   end

   // Advance state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= esckd_pkg::ST_IDLE;
         elapsed_ff <= '0;
      end else if (accept) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

[rtl/esckd_key_fifo.sv]
// ============================================================================
// Escape sequence key result queue
// Register queue taking up to two keys a beat and handing out one a beat.
// ============================================================================
`timescale 1ns / 1ps

module esckd_key_fifo #(
   parameter int DEPTH = esckd_pkg::RSP_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        push,
   input  esckd_pkg::key_beat_type           beat,
   input  logic                              pop,
   output logic                              valid,
   output logic [7:0]                        key_code,
   output logic                              last,
   output logic [$clog2(DEPTH+1)-1:0]        occupancy
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);

   logic [7:0]       key_ff  [DEPTH];
   logic             last_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Pointer and count updates
   always_comb begin
      wr_ptr_next = ptr_inc(wr_ptr_ff);
      unique case (push)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + OCC_W'(push) - OCC_W'(pop);
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the first key and, for a pair, the second behind it
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if ((push != 2'd0) && (wr_ptr_ff == PTR_W'(i))) begin
            key_ff[i]  <= beat.key0;
            last_ff[i] <= (push == 2'd1);
         end else if ((push == 2'd2) && (wr_ptr_next == PTR_W'(i))) begin
            key_ff[i]  <= beat.key1;
            last_ff[i] <= 1'b1;
         end
      end
   end

   assign valid     = (count_ff != '0);
   assign key_code  = key_ff[rd_ptr_ff];
   assign last      = last_ff[rd_ptr_ff];
   assign occupancy = count_ff;

endmodule

[verif/testbench.sv]
// ============================================================================
// Escape sequence key decoder testbench
// Drives terminal bytes and ticks through the req channel, writes the escape
// timeout through the csr port between phases, and checks every rsp beat
// against a cycle-free parser model kept in this file. Both sides idle and
// stall at random in several phases. One phase holds off the rsp side long
// enough to back up the input.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_LEN   = 8;
   localparam int RSP_HOLD_LEN = 300;

   typedef struct packed {
      logic       operation;
      logic [7:0] byte_value;
   } term_beat_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic       last;
   } rsp_key_type;

   // DUT ports, inputs all driven to known values from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = esckd_pkg::OP_BYTE;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_key_code;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_escape_timeout_ticks = esckd_pkg::TIMEOUT_RESET;

   // Stimulus and expected keys
   term_beat_type term_pending[$];
   rsp_key_type   keys_expected[$];

   // Parser model state
   esckd_pkg::parse_state_type dec_state   = esckd_pkg::ST_IDLE;
   logic [15:0]                dec_elapsed = 16'd0;
   logic [15:0]                dec_timeout = esckd_pkg::TIMEOUT_RESET;

   // Idling controls; percentages and hold requests set by the sequencer at the falling edge
   int send_idle_pct     = 0;
   int recv_stall_pct    = 0;
   int rsp_hold_requests = 0;
   int rsp_holds_done    = 0;
   int rsp_hold_left     = 0;

   // Bookkeeping
   int beats_queued         = 0;
   int beats_accepted       = 0;
   int keys_checked         = 0;
   int lone_escape_timeouts = 0;
   int input_stall_cycles   = 0;
   int mismatches           = 0;
   int cycle_count          = 0;

   escape_sequence_key_decoder_top dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_operation            (req_operation),
      .req_byte_value           (req_byte_value),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_key_code             (rsp_key_code),
      .rsp_last                 (rsp_last),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_escape_timeout_ticks (csr_escape_timeout_ticks)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Key for a byte seen outside a sequence, none when unmapped
   function automatic logic [7:0] idle_key_of(input logic [7:0] b);
      if (b >= "1" && b <= "9") begin
         return b - 8'h2F;
      end
      case (b)
         "0":     return 8'd11;
         " ":     return 8'd57;
         "q":     return 8'd16;
         "Q":     return 8'd16;
         8'h0A:   return 8'd28;
         default: return esckd_pkg::KC_NONE;
      endcase
   endfunction

   // Arrow key for a final byte, none for the other finals
   function automatic logic [7:0] arrow_key_of(input logic [7:0] b);
      case (b)
         "A":     return 8'd103;
         "B":     return 8'd108;
         "C":     return 8'd106;
         "D":     return 8'd105;
         default: return esckd_pkg::KC_NONE;
      endcase
   endfunction

   // Advance the parser model by one accepted beat and queue its keys
   function automatic void decode_term_beat(input logic op, input logic [7:0] b);
      logic [16:0] next_count;
      logic [7:0]  keys [2];
      logic [7:0]  k;
      int          n;
      n = 0;
      if (op == esckd_pkg::OP_TICK) begin
         if (dec_state != esckd_pkg::ST_IDLE) begin
            next_count = {1'b0, dec_elapsed} + 17'd1;
            if (next_count > {1'b0, dec_timeout}) begin
               keys[n] = esckd_pkg::KC_ESC;
               n++;
               dec_state = esckd_pkg::ST_IDLE;
               lone_escape_timeouts++;
            end else begin
               dec_elapsed = next_count[15:0];
            end
         end
      end else begin
         case (dec_state)
            esckd_pkg::ST_ESC: begin
               if (b == esckd_pkg::BYTE_LB) begin
                  dec_state = esckd_pkg::ST_WAIT;
               end else begin
                  keys[n] = esckd_pkg::KC_ESC;
                  n++;
                  // a second ESC keeps the sequence open and the count running
                  if (b != esckd_pkg::BYTE_ESC) begin
                     k = idle_key_of(b);
                     if (k != esckd_pkg::KC_NONE) begin
                        keys[n] = k;
                        n++;
                     end
                     dec_state = esckd_pkg::ST_IDLE;
                  end
               end
            end
            esckd_pkg::ST_WAIT: begin
               if (b >= esckd_pkg::FINAL_LO && b <= esckd_pkg::FINAL_HI) begin
                  k = arrow_key_of(b);
                  if (k != esckd_pkg::KC_NONE) begin
                     keys[n] = k;
                     n++;
                  end
                  dec_state = esckd_pkg::ST_IDLE;
               end
            end
            default: begin
               if (b == esckd_pkg::BYTE_ESC) begin
                  dec_state   = esckd_pkg::ST_ESC;
                  dec_elapsed = 16'd0;
               end else begin
                  k = idle_key_of(b);
                  if (k != esckd_pkg::KC_NONE) begin
                     keys[n] = k;
                     n++;
                  end
               end
            end
         endcase
      end
      for (int i = 0; i < n; i++) begin
         keys_expected.push_back(rsp_key_type'{keys[i], (i == n - 1)});
      end
   endfunction

   // Req driver: present the next pending beat once the slot is free
   always @(posedge clock) begin : req_driver
      term_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (term_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = term_pending.pop_front();
            req_valid      <= 1'b1;
            req_operation  <= nxt.operation;
            req_byte_value <= nxt.byte_value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Rsp ready: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ready     <= 1'b0;
      end else if (rsp_holds_done != rsp_hold_requests) begin
         rsp_holds_done <= rsp_holds_done + 1;
         rsp_hold_left  <= RSP_HOLD_LEN;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on req and csr beats, check rsp beats in order
   always @(posedge clock) begin : monitor
      rsp_key_type want;
      if (reset) begin
         dec_state   = esckd_pkg::ST_IDLE;
         dec_elapsed = 16'd0;
         dec_timeout = esckd_pkg::TIMEOUT_RESET;
         keys_expected.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            dec_timeout = csr_escape_timeout_ticks;
         end
         if (req_valid && req_ready) begin
            decode_term_beat(req_operation, req_byte_value);
            beats_accepted++;
         end
         if (req_valid && !req_ready) begin
            input_stall_cycles++;
         end
         if (rsp_valid && rsp_ready) begin
            if (keys_expected.size() == 0) begin
               $display("%0t ns: unexpected key, expected none, got key_code %0d last %0b",
                        $time, rsp_key_code, rsp_last);
               mismatches++;
            end else begin
               want = keys_expected.pop_front();
               keys_checked++;
               if (rsp_key_code !== want.key_code) begin
                  $display("%0t ns: key_code mismatch, expected %0d, got %0d",
                           $time, want.key_code, rsp_key_code);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t ns: last mismatch, expected %0b, got %0b",
                           $time, want.last, rsp_last);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: run stopped after %0d cycles, %0d keys still due",
                  $time, cycle_count, keys_expected.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void add_beat(input logic op, input logic [7:0] b);
      term_pending.push_back(term_beat_type'{op, b});
      beats_queued++;
   endfunction

   function automatic logic [7:0] any_mapped_byte();
      int idx;
      idx = $urandom_range(0, 14);
      case (idx)
         10:      return " ";
         11:      return "q";
         12:      return "Q";
         13:      return 8'h0A;
         14:      return esckd_pkg::BYTE_ESC;
         default: return 8'(8'h30 + idx);
      endcase
   endfunction

   // Queue random traffic: mostly well-formed sequences, some noise
   function automatic void queue_random_traffic(input int count);
      int   start;
      int   kind;
      logic [7:0] mid;
      start = beats_queued;
      while (beats_queued - start < count) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            // CSI sequence with optional intermediates and ticks
            add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
            add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_LB);
            repeat ($urandom_range(0, 2)) begin
               mid = 8'($urandom_range(0, 255));
               if (mid >= esckd_pkg::FINAL_LO && mid <= esckd_pkg::FINAL_HI) begin
                  mid = mid ^ 8'h80;
               end
               add_beat(esckd_pkg::OP_BYTE, mid);
               if ($urandom_range(3) == 0) begin
                  add_beat(esckd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
               end
            end
            if ($urandom_range(9) < 7) begin
               add_beat(esckd_pkg::OP_BYTE, 8'(8'h41 + $urandom_range(0, 3)));
            end else begin
               add_beat(esckd_pkg::OP_BYTE,
                        8'($urandom_range(esckd_pkg::FINAL_LO, esckd_pkg::FINAL_HI)));
            end
         end else if (kind < 45) begin
            // ESC followed by a plain byte, maybe after a second ESC
            add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
            if ($urandom_range(9) < 3) begin
               add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
            end
            if ($urandom_range(1) == 0) begin
               add_beat(esckd_pkg::OP_BYTE, any_mapped_byte());
            end else begin
               add_beat(esckd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end
         end else if (kind < 60) begin
            // open sequence left to time out
            add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
            if ($urandom_range(1) == 0) begin
               add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_LB);
            end
            repeat ($urandom_range(0, 7)) begin
               add_beat(esckd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            end
         end else if (kind < 85) begin
            add_beat(esckd_pkg::OP_BYTE, any_mapped_byte());
         end else begin
            add_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
   endfunction

   // Block until nothing is pending, in flight or due
   task automatic wait_for_drain();
      do @(negedge clock);
      while (term_pending.size() != 0 || req_valid || keys_expected.size() != 0);
   endtask

   task automatic set_escape_timeout(input logic [15:0] ticks);
      wait_for_drain();
      repeat (SETTLE_LEN) @(negedge clock);
      @(posedge clock);
      csr_valid                <= 1'b1;
      csr_escape_timeout_ticks <= ticks;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] ticks, input int send_pct,
                            input int recv_pct, input int count);
      set_escape_timeout(ticks);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      queue_random_traffic(count);
   endtask

   // Sequencer
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: plain map edges, unmapped bytes, idle tick, escape sequence shapes
      add_beat(esckd_pkg::OP_BYTE, "0");
      add_beat(esckd_pkg::OP_BYTE, "9");
      add_beat(esckd_pkg::OP_BYTE, " ");
      add_beat(esckd_pkg::OP_BYTE, "q");
      add_beat(esckd_pkg::OP_BYTE, "Q");
      add_beat(esckd_pkg::OP_BYTE, 8'h0A);
      add_beat(esckd_pkg::OP_BYTE, 8'h00);
      add_beat(esckd_pkg::OP_BYTE, 8'hFF);
      add_beat(esckd_pkg::OP_TICK, 8'hFF);
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_LB);
      add_beat(esckd_pkg::OP_BYTE, "A");
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_LB);
      add_beat(esckd_pkg::OP_BYTE, 8'h20);
      add_beat(esckd_pkg::OP_TICK, 8'h00);
      add_beat(esckd_pkg::OP_BYTE, "D");
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_LB);
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::FINAL_HI);
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
      add_beat(esckd_pkg::OP_BYTE, "5");
      add_beat(esckd_pkg::OP_BYTE, esckd_pkg::BYTE_ESC);
      add_beat(esckd_pkg::OP_BYTE, "x");

      // Random phases across timeout settings and idling modes
      run_phase(16'd3,     0,  0,  90);
      run_phase(16'd1,     79, 0,  80);
      run_phase(16'd0,     0,  79, 70);
      run_phase(16'hFFFF,  26, 26, 70);

      // Long rsp hold-off while req keeps coming, then a sender pause
      set_escape_timeout(16'd5);
      @(negedge clock);
      send_idle_pct  = 26;
      recv_stall_pct = 26;
      rsp_hold_requests++;
      queue_random_traffic(40);
      wait_for_drain();
      queue_random_traffic(40);

      run_phase(16'd2, 0, 0, 60);

      wait_for_drain();
      repeat (SETTLE_LEN) @(negedge clock);

      $display("Covered %0d req beats and %0d keys over seven timeout settings,",
               beats_accepted, keys_checked);
      $display("with %0d escapes by timeout and %0d cycles of input back-pressure.",
               lone_escape_timeouts, input_stall_cycles);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
